@@ rtl/selective_repeat_receiver_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Selective repeat receiver assertion macros
// Shorthand for clocked properties disabled while the active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sru: same-cycle check failed");

// Next-cycle implication.
`define SRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sru: next-cycle check failed");

`endif

@@ rtl/sru_pkg.sv @@
// ---------------------------------------------------------------------------
// Selective repeat receiver package
// Field widths, result kinds and verdict codes shared by the channels and
// the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package sru_pkg;

  localparam int SEQ_W     = 3;
  localparam int PAYLOAD_W = 32;
  localparam int ACK_W     = 4;
  localparam int VERDICT_W = 2;

  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;
  typedef logic [VERDICT_W-1:0] verdict_t;
  typedef logic signed [ACK_W-1:0] ack_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam verdict_t VERDICT_IN_WINDOW = 2'd0;
  localparam verdict_t VERDICT_PREV_WIN  = 2'd1;
  localparam verdict_t VERDICT_BAD_SUM   = 2'd2;
  localparam verdict_t VERDICT_OUT_RANGE = 2'd3;

  localparam ack_t ACK_NONE = 4'sb1111;

endpackage

`default_nettype wire

@@ rtl/sru_if.sv @@
// ---------------------------------------------------------------------------
// Selective repeat receiver channels
// Valid/ready channels for arriving packets and for result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface sru_in_if;
  import sru_pkg::*;

  logic     valid;
  logic     ready;
  seq_t     seq_number;
  logic     checksum_good;
  payload_t payload_word;

  modport source (output valid, output seq_number, output checksum_good,
                  output payload_word, input ready);
  modport sink   (input valid, input seq_number, input checksum_good,
                  input payload_word, output ready);
endinterface

interface sru_out_if;
  import sru_pkg::*;

  logic     valid;
  logic     ready;
  logic     kind;
  seq_t     delivered_seq;
  payload_t delivered_data;
  ack_t     ack_number;
  verdict_t verdict;
  logic     last_of_run;

  modport source (output valid, output kind, output delivered_seq,
                  output delivered_data, output ack_number, output verdict,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input delivered_seq,
                  input delivered_data, input ack_number, input verdict,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/selective_repeat_receiver_unit.sv @@
// ---------------------------------------------------------------------------
// Selective repeat receiver
// Buffers good in-window packets, delivers the in-order run at the window
// base and follows every packet with one acknowledgement item.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  in_ch     sink       one arriving packet per item
//  out_ch    source     deliveries in order, then one ack item per packet
//
//  A packet passes through an evaluate state, then a run state when it lands
//  on the window base, and an ack state; the run reads each delivered entry
//  once from the payload store. Results leave through an output register,
//  so a stalled result only holds the sequencer, never the data.
//  Reset clears the marks, the window base and the last ack; the payload
//  store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver_unit #(
  parameter int SEQ_COUNT  = 8,
  parameter int WINDOW     = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sru_in_if.sink     in_ch,
  sru_out_if.source  out_ch
);
  import sru_pkg::*;

  localparam int IW    = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int CW    = ((IW > SEQ_W) ? IW : SEQ_W) + 1;
  localparam int LIMIT = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
  localparam int WMOD  = WINDOW % SEQ_COUNT;
  localparam int CNTW  = $clog2(LIMIT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_ACK  = 2'd3;

  typedef logic [IW-1:0] idx_t;
  typedef logic [CW-1:0] wide_t;

  logic [1:0]            state_r, state_nxt;
  seq_t                  seq_r;
  logic                  good_r;
  logic [DATA_WIDTH-1:0] word_r;
  verdict_t              verdict_r;
  idx_t                  base_r;
  ack_t                  ack_r;
  logic [SEQ_COUNT-1:0]  marks_r;
  idx_t                  j_r;
  logic [CNTW-1:0]       count_r;
  logic                  rd_pend_r;
  idx_t                  pend_seq_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] store_mem [SEQ_COUNT];

  logic                  out_valid_r;
  logic                  out_kind_r;
  seq_t                  out_dseq_r;
  payload_t              out_ddata_r;
  ack_t                  out_ack_r;
  verdict_t              out_verdict_r;
  logic                  out_last_r;

  wide_t    seq_ext, base_ext, off, prev_sum, prev;
  idx_t     seq_idx, j_inc;
  logic     in_range, in_win, in_prev;
  verdict_t verdict_nxt;
  logic     accept, mem_we, out_load_ok, advance, can_issue;
  logic     issue, load_deliver, load_ack, run_done;

  assign accept   = in_ch.valid && in_ch.ready;
  assign seq_ext  = wide_t'(seq_r);
  assign base_ext = wide_t'(base_r);
  assign seq_idx  = seq_ext[IW-1:0];
  assign in_range = seq_ext < wide_t'(SEQ_COUNT);
  assign off      = (seq_ext >= base_ext) ? (seq_ext - base_ext)
                                          : (seq_ext + wide_t'(SEQ_COUNT) - base_ext);
  assign prev_sum = off + wide_t'(WMOD);
  assign prev     = (prev_sum >= wide_t'(SEQ_COUNT)) ? (prev_sum - wide_t'(SEQ_COUNT))
                                                     : prev_sum;
  assign in_win   = off < wide_t'(LIMIT);
  assign in_prev  = prev < wide_t'(LIMIT);

  always_comb begin
    priority if (!good_r) begin
      verdict_nxt = VERDICT_BAD_SUM;
    end else if (!in_range) begin
      verdict_nxt = VERDICT_OUT_RANGE;
    end else if (in_win) begin
      verdict_nxt = VERDICT_IN_WINDOW;
    end else if (in_prev) begin
      verdict_nxt = VERDICT_PREV_WIN;
    end else begin
      verdict_nxt = VERDICT_OUT_RANGE;
    end
  end

  assign mem_we = (state_r == ST_EVAL) && (verdict_nxt == VERDICT_IN_WINDOW)
                  && !marks_r[seq_idx];

  assign j_inc        = (j_r == idx_t'(SEQ_COUNT - 1)) ? '0 : (j_r + idx_t'(1));
  assign out_load_ok  = !out_valid_r || out_ch.ready;
  assign advance      = !rd_pend_r || out_load_ok;
  assign can_issue    = (count_r < CNTW'(LIMIT)) && marks_r[j_r];
  assign issue        = (state_r == ST_RUN) && advance && can_issue;
  assign load_deliver = (state_r == ST_RUN) && rd_pend_r && out_load_ok;
  assign run_done     = (state_r == ST_RUN) && !rd_pend_r && !can_issue;
  assign load_ack     = (state_r == ST_ACK) && out_load_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((verdict_nxt == VERDICT_IN_WINDOW) && (seq_idx == base_r)) begin
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        if (load_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      ack_r       <= ACK_NONE;
      marks_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EVAL) begin
        if (mem_we) begin
          marks_r[seq_idx] <= 1'b1;
        end
        if ((verdict_nxt == VERDICT_IN_WINDOW) || (verdict_nxt == VERDICT_PREV_WIN)) begin
          ack_r <= ack_t'({1'b0, seq_r});
        end
      end
      if (issue) begin
        marks_r[j_r] <= 1'b0;
      end
      if (state_r == ST_RUN && advance) begin
        rd_pend_r <= can_issue;
      end
      if (run_done) begin
        base_r <= j_r;
      end
      if (load_deliver || load_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r  <= in_ch.seq_number;
      good_r <= in_ch.checksum_good;
      word_r <= DATA_WIDTH'(in_ch.payload_word);
    end
    if (state_r == ST_EVAL) begin
      verdict_r <= verdict_nxt;
      j_r       <= base_r;
      count_r   <= '0;
    end
    if (issue) begin
      j_r        <= j_inc;
      count_r    <= count_r + CNTW'(1);
      pend_seq_r <= j_r;
    end
    if (load_deliver) begin
      out_kind_r    <= KIND_DELIVER;
      out_dseq_r    <= seq_t'(pend_seq_r);
      out_ddata_r   <= payload_t'(rd_data_r);
      out_ack_r     <= '0;
      out_verdict_r <= VERDICT_IN_WINDOW;
      out_last_r    <= 1'b0;
    end else if (load_ack) begin
      out_kind_r    <= KIND_ACK;
      out_dseq_r    <= '0;
      out_ddata_r   <= '0;
      out_ack_r     <= ack_r;
      out_verdict_r <= verdict_r;
      out_last_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[seq_idx] <= word_r;
    end
    if (issue) begin
      rd_data_r <= store_mem[j_r];
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.delivered_seq  = out_dseq_r;
  assign out_ch.delivered_data = out_ddata_r;
  assign out_ch.ack_number     = out_ack_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.last_of_run    = out_last_r;

`include "selective_repeat_receiver_unit_assert.svh"

  `SRU_ASSERT_NEXT(a_ack_loaded, clk, rst_n, load_ack, out_valid_r && out_last_r && (out_kind_r == KIND_ACK))
  `SRU_ASSERT_NEXT(a_base_moves_in_run, clk, rst_n, state_r != ST_RUN, $stable(base_r))
  `SRU_ASSERT_NOW(a_idle_no_read, clk, rst_n, state_r == ST_IDLE, !rd_pend_r)

endmodule

`default_nettype wire
